### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define SDR_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion, checked at every edge.
`define SDR_ASSERT(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

### src/sdr_pkg.sv
// Shared widths, constants and payload types of the spring relaxation pipeline.
package sdr_pkg;

   localparam int CW     = 32;
   localparam int DW     = CW + 1;
   localparam int SQW    = 2 * DW;
   localparam int LW     = DW;
   localparam int RSTW   = 31;
   localparam int KW     = 17;
   localparam int EW     = (LW > RSTW) ? LW : RSTW;
   localparam int PW     = EW + DW;
   localparam int PH     = (PW + 1) / 2;
   localparam int PHI    = PW - PH;
   localparam int NW     = PW + KW;
   localparam int DENW   = LW + 16;
   localparam int QW     = EW + 2;
   localparam int TW     = (NW > DENW + QW) ? NW : DENW + QW;
   localparam int RW     = ((CW > QW + 1) ? CW : QW + 1) + 1;
   localparam int IN_DW  = ((6 * CW + RSTW + 7) / 8) * 8;
   localparam int OUT_DW = ((6 * CW + 7) / 8) * 8;

   localparam logic [KW-1:0] STIFF_RESET = KW'(6554);
   localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

   typedef logic [CW-1:0] coord_type;

   typedef struct packed {
      coord_type [2:0]         a;
      coord_type [2:0]         b;
      logic [2:0][DW-1:0]      dmag;
      logic [2:0]              dneg;
      logic [RSTW-1:0]         rest;
   } geo_type;

   typedef struct packed {
      coord_type [2:0]         a;
      coord_type [2:0]         b;
      logic [2:0]              cneg;
      logic                    lz;
   } fix_type;

endpackage

### src/sdr_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage.
module sdr_sqrt_pipe import sdr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [SQW-1:0]   in_sum,
   input  geo_type          in_geo,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [LW-1:0]    out_root,
   output geo_type          out_geo
);

   logic           v_ff    [LW];
   logic           rdy     [LW];
   logic [SQW-1:0] rem_ff  [LW];
   logic [LW-1:0]  root_ff [LW];
   geo_type        geo_ff  [LW];

   for (genvar k = 0; k < LW; k++) begin : g_stage
      localparam int J = LW - 1 - k;
      logic           vp;
      logic [SQW-1:0] rp;
      logic [LW-1:0]  qp;
      geo_type        gp;
      logic           nx;
      logic [SQW+1:0] t;
      logic           ge;
      logic [SQW-1:0] rem_in;
      logic [LW-1:0]  root_in;

      if (k == 0) begin : g_first
         assign vp = in_valid;
         assign rp = in_sum;
         assign qp = '0;
         assign gp = in_geo;
      end else begin : g_next
         assign vp = v_ff[k-1];
         assign rp = rem_ff[k-1];
         assign qp = root_ff[k-1];
         assign gp = geo_ff[k-1];
      end

      if (k == LW - 1) begin : g_last
         assign nx = out_ready;
      end else begin : g_mid
         assign nx = rdy[k+1];
      end

      assign rdy[k]  = !v_ff[k] || nx;
      assign t       = ({{(SQW+2-LW){1'b0}}, qp} << (J + 1)) + ((SQW+2)'(1) << (2 * J));
      assign ge      = {2'b00, rp} >= t;
      assign rem_in  = ge ? SQW'({2'b00, rp} - t) : rp;
      assign root_in = qp | (LW'(ge) << J);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= vp;
         end
         if (rdy[k]) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            geo_ff[k]  <= gp;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[LW-1];
   assign out_root  = root_ff[LW-1];
   assign out_geo   = geo_ff[LW-1];

endmodule

### src/sdr_div_pipe.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module sdr_div_pipe import sdr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [2:0][NW-1:0]   in_num,
   input  logic [DENW-1:0]      in_den,
   input  fix_type              in_fix,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [2:0][QW-1:0]   out_quo,
   output fix_type              out_fix
);

   logic                v_ff   [QW];
   logic                rdy    [QW];
   logic [2:0][NW-1:0]  rem_ff [QW];
   logic [2:0][QW-1:0]  quo_ff [QW];
   logic [DENW-1:0]     den_ff [QW];
   fix_type             fix_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int J = QW - 1 - k;
      logic               vp;
      logic [2:0][NW-1:0] rp;
      logic [2:0][QW-1:0] qp;
      logic [DENW-1:0]    dp;
      fix_type            fp;
      logic               nx;
      logic [TW-1:0]      t;
      logic [2:0][NW-1:0] rem_in;
      logic [2:0][QW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign vp = in_valid;
         assign rp = in_num;
         assign qp = '0;
         assign dp = in_den;
         assign fp = in_fix;
      end else begin : g_next
         assign vp = v_ff[k-1];
         assign rp = rem_ff[k-1];
         assign qp = quo_ff[k-1];
         assign dp = den_ff[k-1];
         assign fp = fix_ff[k-1];
      end

      if (k == QW - 1) begin : g_last
         assign nx = out_ready;
      end else begin : g_mid
         assign nx = rdy[k+1];
      end

      assign rdy[k] = !v_ff[k] || nx;
      assign t      = TW'(dp) << J;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            if (TW'(rp[i]) >= t) begin
               rem_in[i] = NW'(TW'(rp[i]) - t);
               quo_in[i] = qp[i] | (QW'(1) << J);
            end else begin
               rem_in[i] = rp[i];
               quo_in[i] = qp[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= vp;
         end
         if (rdy[k]) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            den_ff[k] <= dp;
            fix_ff[k] <= fp;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_fix   = fix_ff[QW-1];

endmodule

### src/spring_distance_relaxation.sv
// Spring distance relaxation: takes one spring per clock (ends A and B, rest length) and
// returns both ends moved along the spring by (rest - length) * stiffness, saturated to Q16.16.
// The pipeline accepts a new spring every cycle while the result output does not stall it;
// each spring passes through the square root (one root bit per stage, 33 stages) and the
// divider (one quotient bit per stage, 35 stages) plus eight arithmetic stages, the first of
// which loads when the spring is accepted. Any stage that holds
// no spring keeps accepting while a result waits. Write stiffness only while no spring is in
// flight; it resets to 0.1.
module spring_distance_relaxation import sdr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [KW-1:0]     csr_data,    // stiffness
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [IN_DW-1:0]  req_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, rest_len
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OUT_DW-1:0] rsp_tdata,   // new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z
   output logic [0:0]        rsp_tuser    // sat_flag
);

   logic [KW-1:0] stiff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= STIFF_RESET;
      end else if (csr_valid) begin
         stiff_ff <= csr_data;
      end
   end
   assign csr_ready = 1'b1;

   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic sq_ready, sq_valid, dv_ready, dv_valid;

   // stage 1: separation
   geo_type geo1_in, geo1_ff;
   always_comb begin
      logic signed [DW-1:0] d;
      for (int i = 0; i < 3; i++) begin
         geo1_in.a[i] = req_tdata[i*CW +: CW];
         geo1_in.b[i] = req_tdata[(3+i)*CW +: CW];
         d = $signed({geo1_in.b[i][CW-1], geo1_in.b[i]})
           - $signed({geo1_in.a[i][CW-1], geo1_in.a[i]});
         geo1_in.dneg[i] = d[DW-1];
         geo1_in.dmag[i] = d[DW-1] ? DW'(-d) : DW'(d);
      end
      geo1_in.rest = req_tdata[6*CW +: RSTW];
   end

   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_tvalid;
      end
      if (rdy1) begin
         geo1_ff <= geo1_in;
      end
   end

   // stage 2: squares
   geo_type             geo2_ff;
   logic [2:0][SQW-1:0] sq2_in, sq2_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq2_in[i] = {{(SQW-DW){1'b0}}, geo1_ff.dmag[i]} * {{(SQW-DW){1'b0}}, geo1_ff.dmag[i]};
      end
   end

   assign rdy2 = !v2_ff || rdy3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
      if (rdy2) begin
         geo2_ff <= geo1_ff;
         sq2_ff  <= sq2_in;
      end
   end

   // stage 3: squared length
   geo_type        geo3_ff;
   logic [SQW-1:0] sum3_in, sum3_ff;
   assign sum3_in = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
   assign rdy3    = !v3_ff || sq_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
      if (rdy3) begin
         geo3_ff <= geo2_ff;
         sum3_ff <= sum3_in;
      end
   end

   logic [LW-1:0] sq_root;
   geo_type       sq_geo;

   sdr_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_ready  (sq_ready),
      .in_sum    (sum3_ff),
      .in_geo    (geo3_ff),
      .out_valid (sq_valid),
      .out_ready (rdy4),
      .out_root  (sq_root),
      .out_geo   (sq_geo)
   );

   // stage 4: length error
   geo_type        geo4_ff;
   logic [LW-1:0]  len4_ff;
   logic [EW-1:0]  em4_in, em4_ff;
   logic           eneg4_in, eneg4_ff;
   always_comb begin
      logic signed [EW:0] e;
      e = $signed({{(EW+1-RSTW){1'b0}}, sq_geo.rest}) - $signed({{(EW+1-LW){1'b0}}, sq_root});
      eneg4_in = e[EW];
      em4_in   = e[EW] ? EW'(-e) : EW'(e);
   end

   assign rdy4 = !v4_ff || rdy5;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= sq_valid;
      end
      if (rdy4) begin
         geo4_ff  <= sq_geo;
         len4_ff  <= sq_root;
         em4_ff   <= em4_in;
         eneg4_ff <= eneg4_in;
      end
   end

   // stage 5: error times separation
   fix_type            fix5_in, fix5_ff;
   logic [LW-1:0]      len5_ff;
   logic [2:0][PW-1:0] p5_in, p5_ff;
   always_comb begin
      fix5_in.a  = geo4_ff.a;
      fix5_in.b  = geo4_ff.b;
      fix5_in.lz = (len4_ff == '0);
      for (int i = 0; i < 3; i++) begin
         fix5_in.cneg[i] = eneg4_ff ^ geo4_ff.dneg[i];
         p5_in[i] = {{(PW-EW){1'b0}}, em4_ff} * {{(PW-DW){1'b0}}, geo4_ff.dmag[i]};
      end
   end

   assign rdy5 = !v5_ff || rdy6;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (rdy5) begin
         v5_ff <= v4_ff;
      end
      if (rdy5) begin
         fix5_ff <= fix5_in;
         len5_ff <= len4_ff;
         p5_ff   <= p5_in;
      end
   end

   // stage 6: stiffness partial products
   fix_type                  fix6_ff;
   logic [LW-1:0]            len6_ff;
   logic [2:0][PH+KW-1:0]    pl6_in, pl6_ff;
   logic [2:0][PHI+KW-1:0]   ph6_in, ph6_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pl6_in[i] = {{KW{1'b0}}, p5_ff[i][PH-1:0]} * {{PH{1'b0}}, stiff_ff};
         ph6_in[i] = {{KW{1'b0}}, p5_ff[i][PW-1:PH]} * {{PHI{1'b0}}, stiff_ff};
      end
   end

   assign rdy6 = !v6_ff || rdy7;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (rdy6) begin
         v6_ff <= v5_ff;
      end
      if (rdy6) begin
         fix6_ff <= fix5_ff;
         len6_ff <= len5_ff;
         pl6_ff  <= pl6_in;
         ph6_ff  <= ph6_in;
      end
   end

   // stage 7: dividend and divisor
   fix_type            fix7_ff;
   logic [DENW-1:0]    den7_ff;
   logic [2:0][NW-1:0] num7_in, num7_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num7_in[i] = (NW'(ph6_ff[i]) << PH) + NW'(pl6_ff[i]);
      end
   end

   assign rdy7 = !v7_ff || dv_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (rdy7) begin
         v7_ff <= v6_ff;
      end
      if (rdy7) begin
         fix7_ff <= fix6_ff;
         den7_ff <= {len6_ff, 16'b0};
         num7_ff <= num7_in;
      end
   end

   logic [2:0][QW-1:0] dv_quo;
   fix_type            dv_fix;

   sdr_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_ready  (dv_ready),
      .in_num    (num7_ff),
      .in_den    (den7_ff),
      .in_fix    (fix7_ff),
      .out_valid (dv_valid),
      .out_ready (rdy8),
      .out_quo   (dv_quo),
      .out_fix   (dv_fix)
   );

   // stage 8: apply correction and saturate
   logic [OUT_DW-1:0] data8_in, data8_ff;
   logic              sat8_in, sat8_ff;
   always_comb begin
      logic signed [RW-1:0] c;
      logic signed [RW-1:0] na;
      logic signed [RW-1:0] nb;
      logic signed [RW-1:0] qs;
      data8_in = '0;
      sat8_in  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         qs = $signed({{(RW-QW){1'b0}}, dv_quo[i]});
         c  = dv_fix.lz ? '0 : (dv_fix.cneg[i] ? -qs : qs);
         na = $signed({{(RW-CW){dv_fix.a[i][CW-1]}}, dv_fix.a[i]}) - c;
         nb = $signed({{(RW-CW){dv_fix.b[i][CW-1]}}, dv_fix.b[i]}) + c;
         if (na > SAT_HI) begin
            na = SAT_HI;
            sat8_in = 1'b1;
         end else if (na < SAT_LO) begin
            na = SAT_LO;
            sat8_in = 1'b1;
         end
         if (nb > SAT_HI) begin
            nb = SAT_HI;
            sat8_in = 1'b1;
         end else if (nb < SAT_LO) begin
            nb = SAT_LO;
            sat8_in = 1'b1;
         end
         data8_in[i*CW +: CW]     = na[CW-1:0];
         data8_in[(3+i)*CW +: CW] = nb[CW-1:0];
      end
   end

   assign rdy8 = !v8_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (rdy8) begin
         v8_ff <= dv_valid;
      end
      if (rdy8) begin
         data8_ff <= data8_in;
         sat8_ff  <= sat8_in;
      end
   end

   assign rsp_tvalid   = v8_ff;
   assign rsp_tdata    = data8_ff;
   assign rsp_tuser[0] = sat8_ff;

endmodule

### src/sdr_checker.sv
// Port-level checker for the spring relaxation block, bound to the top level.
`include "assert_macros.svh"

module sdr_checker import sdr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [KW-1:0]     csr_data,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [IN_DW-1:0]  req_tdata,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [OUT_DW-1:0] rsp_tdata,
   input logic [0:0]        rsp_tuser
);

   `SDR_ASSERT(a_reset_empties, clock, reset |=> !rsp_tvalid)
   `SDR_ASSERT_RST(a_empty_takes, clock, reset, !rsp_tvalid |-> req_tready)
   `SDR_ASSERT_RST(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `SDR_ASSERT_RST(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind spring_distance_relaxation sdr_checker u_sdr_checker (.*);
